>>> rtl/tss_pkg.sv
`timescale 1ns / 1ps
package tss_pkg;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic CFG_DISCARD_LOW  = 1'b0;
    localparam logic CFG_DISCARD_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] rate;
    } req_t;

    typedef struct packed {
        logic        stats_valid;
        logic [6:0]  sample_count;
        logic [15:0] mean_value;
        logic [31:0] variance_value;
        logic [15:0] std_deviation;
        logic [15:0] min_value;
        logic [15:0] max_value;
    } res_t;

    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
    } cell_ctl_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIVM  = 8'b0010_0000,
        S_DIVV  = 8'b0100_0000,
        S_ROOT  = 8'b1000_0000
    } state_t;

endpackage

>>> rtl/tss_cell.sv
`timescale 1ns / 1ps
module tss_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tss_pkg::cell_ctl_t ctl,
    input  logic [15:0]        sample,
    input  logic [15:0]        left_val,
    input  logic               left_valid,
    input  logic               left_lt,
    input  logic [15:0]        right_val,
    output logic [15:0]        val,
    output logic               valid,
    output logic               lt
);
    import tss_pkg::*;

    logic [15:0] val_reg;
    logic        valid_reg;
    logic        take;

    assign lt = valid_reg && (sample < val_reg);
    // take a value when the new sample lands here or pushes the chain right
    assign take = ctl.insert && (lt || (!valid_reg && left_valid));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            val_reg <= left_lt ? left_val : sample;
        end
        else if (ctl.rotate)
        begin
            val_reg <= right_val;
        end
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

>>> rtl/tss_div.sv
`timescale 1ns / 1ps
module tss_div #(
    parameter int NW = 44,
    parameter int DW = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    import tss_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DW:0]     rem_reg;
    logic [DW-1:0]   div_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     rem_sh;
    logic            ge;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNTW'(NW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/tss_sqrt.sv
`timescale 1ns / 1ps
module tss_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);
    import tss_pkg::*;

    logic [31:0] rad_reg;
    logic [17:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [17:0] rem_sh;
    logic [17:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[15:0], rad_reg[31:30]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // one root bit per cycle, two radicand bits shifted in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[14:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/trimmed_sample_statistics.sv
`timescale 1ns / 1ps
// Trimmed statistics over a store of up to SAMPLE_DEPTH Q8.8 samples.
// Requests arrive on req (valid/ready): op add stores rate, op clear empties
// the store, op compute returns one result on res (valid/ready); other ops
// give no result. Adds to a full store are dropped.
// The store is a chain of insertion cells that keeps samples sorted, so an
// add or clear is taken without leaving idle. A compute rotates the chain
// once around to sum the kept samples and their squares, then runs a
// shift-add multiply, a restoring division for the mean, a second one for
// the variance when more than one sample is kept, and a bit-serial root.
// A compute with too few samples answers in the next cycle, stats_valid low.
// cfg_we/cfg_index/cfg_data write discard_low (0) and discard_high (1); write
// them only while idle. Reset empties the store and clears both registers.
// A stalled result holds in the output register; adds and clears are still
// taken meanwhile, but the next compute waits until the result is taken.
module trimmed_sample_statistics #(
    parameter int SAMPLE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tss_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output tss_pkg::res_t res,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [5:0]    cfg_data
);
    import tss_pkg::*;

    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int IW = $clog2(SAMPLE_DEPTH);
    localparam int KW = (CW > 7) ? CW : 7;
    localparam int SW = 16 + CW;
    localparam int QW = 32 + CW;
    localparam int NW = QW + CW;
    localparam int DW = 2 * CW;

    state_t state_reg, state_next;

    logic [5:0]    dl_reg;
    logic [5:0]    dh_reg;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] last_reg;
    logic [IW-1:0] k_reg;
    logic          p_valid_reg;
    logic [15:0]   p_x_reg;
    logic [31:0]   p_sq_reg;
    logic [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic [NW-1:0] sumsq_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] mul_acc_reg;
    logic [NW-1:0] mul_a_reg;
    logic [CW-1:0] mul_b_reg;
    logic [15:0]   min_reg;
    logic [15:0]   max_reg;
    logic [15:0]   mean_reg;
    logic [31:0]   var_reg;
    res_t          res_reg;
    logic          res_valid_reg;

    logic [15:0]        cell_val   [SAMPLE_DEPTH];
    logic               cell_lt    [SAMPLE_DEPTH];
    logic [SAMPLE_DEPTH-1:0] valid_vec;
    cell_ctl_t          cell_ctl;

    logic          accept;
    logic          enough;
    logic [KW-1:0] fill_k;
    logic [KW-1:0] lo_k;
    logic [KW-1:0] hi_k;
    logic          in_range;
    logic [15:0]   head;

    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [NW-1:0] div_q;
    logic          sqrt_start;
    logic [31:0]   sqrt_in;
    logic          sqrt_done;
    logic [15:0]   sqrt_root;
    logic [31:0]   var_sat;

    assign head   = cell_val[0];
    assign fill_k = KW'(fill_count_reg);
    assign lo_k   = KW'(dl_reg);
    assign hi_k   = KW'(dh_reg);
    assign enough = fill_k > (lo_k + hi_k);

    assign req_ready = (state_reg == S_IDLE) && !(res_valid_reg && req.op == OP_COMPUTE);
    assign accept    = req_valid && req_ready;

    assign cell_ctl.insert = accept && (req.op == OP_ADD)
                             && (fill_count_reg < CW'(SAMPLE_DEPTH));
    assign cell_ctl.clear  = accept && (req.op == OP_CLEAR);
    assign cell_ctl.rotate = (state_reg == S_SCAN);

    genvar gi;
    generate
        for (gi = 0; gi < SAMPLE_DEPTH; gi++)
        begin : g_cell
            logic [15:0] lv;
            logic        lvd;
            logic        llt;
            if (gi == 0)
            begin : g_head
                assign lv  = 16'd0;
                assign lvd = 1'b1;
                assign llt = 1'b0;
            end
            else
            begin : g_body
                assign lv  = cell_val[gi-1];
                assign lvd = valid_vec[gi-1];
                assign llt = cell_lt[gi-1];
            end
            tss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .sample     (req.rate),
                .left_val   (lv),
                .left_valid (lvd),
                .left_lt    (llt),
                .right_val  (cell_val[(gi + 1) % SAMPLE_DEPTH]),
                .val        (cell_val[gi]),
                .valid      (valid_vec[gi]),
                .lt         (cell_lt[gi])
            );
        end
    endgenerate

    assign in_range = (KW'(k_reg) >= lo_k) && (KW'(k_reg) <= KW'(last_reg));

    assign var_sat = (div_q[NW-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];

    // next state and unit starts
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = NW'(sum_reg);
        div_divisor  = DW'(used_reg);
        sqrt_start   = 1'b0;
        sqrt_in      = var_sat;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.op == OP_COMPUTE && enough)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (k_reg == IW'(SAMPLE_DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if ((mul_b_reg >> 1) == '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVM;
                end
            end
            S_DIVM:
            begin
                if (div_done)
                begin
                    if (used_reg > CW'(1))
                    begin
                        div_start    = 1'b1;
                        div_dividend = mul_acc_reg - sumsq_reg;
                        div_divisor  = den_reg;
                        state_next   = S_DIVV;
                    end
                    else
                    begin
                        sqrt_start = 1'b1;
                        sqrt_in    = 32'd0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_DIVV:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dl_reg         <= '0;
            dh_reg         <= '0;
            fill_count_reg <= '0;
            k_reg          <= '0;
            p_valid_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_DISCARD_LOW)
                begin
                    dl_reg <= cfg_data;
                end
                else
                begin
                    dh_reg <= cfg_data;
                end
            end
            if (cell_ctl.insert)
            begin
                fill_count_reg <= fill_count_reg + CW'(1);
            end
            else if (cell_ctl.clear)
            begin
                fill_count_reg <= '0;
            end
            if (state_reg == S_SCAN)
            begin
                k_reg <= k_reg + IW'(1);
            end
            else
            begin
                k_reg <= '0;
            end
            p_valid_reg <= (state_reg == S_SCAN) && in_range;
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if ((accept && req.op == OP_COMPUTE && !enough)
                || (state_reg == S_ROOT && sqrt_done))
            begin
                res_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.op == OP_COMPUTE)
        begin
            used_reg <= CW'(fill_k - lo_k - hi_k);
            last_reg <= CW'(fill_k - hi_k - KW'(1));
            sum_reg  <= '0;
            sq_reg   <= '0;
            if (!enough)
            begin
                res_reg <= '{stats_valid: 1'b0, sample_count: 7'(fill_count_reg),
                             mean_value: '0, variance_value: '0, std_deviation: '0,
                             min_value: '0, max_value: '0};
            end
        end
        else if (p_valid_reg)
        begin
            sum_reg <= sum_reg + SW'(p_x_reg);
            sq_reg  <= sq_reg + QW'(p_sq_reg);
        end
        // register the square before it is accumulated
        p_x_reg  <= head;
        p_sq_reg <= head * head;
        if (state_reg == S_SCAN)
        begin
            if (KW'(k_reg) == lo_k)
            begin
                min_reg <= head;
            end
            if (KW'(k_reg) == KW'(last_reg))
            begin
                max_reg <= head;
            end
        end
        if (state_reg == S_PREP)
        begin
            sumsq_reg   <= NW'(sum_reg) * NW'(sum_reg);
            den_reg     <= DW'(used_reg) * DW'(used_reg - CW'(1));
            mul_acc_reg <= '0;
            mul_a_reg   <= NW'(sq_reg);
            mul_b_reg   <= used_reg;
        end
        else if (state_reg == S_MUL)
        begin
            if (mul_b_reg[0])
            begin
                mul_acc_reg <= mul_acc_reg + mul_a_reg;
            end
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
        if (state_reg == S_DIVM && div_done)
        begin
            mean_reg <= div_q[15:0];
            var_reg  <= '0;
        end
        if (state_reg == S_DIVV && div_done)
        begin
            var_reg <= var_sat;
        end
        if (state_reg == S_ROOT && sqrt_done)
        begin
            res_reg.stats_valid    <= 1'b1;
            res_reg.sample_count   <= 7'(fill_count_reg);
            res_reg.mean_value     <= mean_reg;
            res_reg.variance_value <= var_reg;
            res_reg.std_deviation  <= sqrt_root;
            res_reg.min_value      <= min_reg;
            res_reg.max_value      <= max_reg;
        end
    end

    tss_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    tss_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_count_reg))
        else $error("fill count differs from occupied cells");

    a_scan_keeps_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(valid_vec))
        else $error("occupancy changed during rotation");

    a_result_from_root: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) && $past(state_reg != S_IDLE) |-> $past(state_reg == S_ROOT))
        else $error("result raised outside root completion");
`endif

endmodule

>>> tb/trimmed_sample_statistics_tb.sv
`timescale 1ns / 1ps
module trimmed_sample_statistics_tb;
    import tss_pkg::*;

    localparam int DEPTH = 64;

    class stats_scoreboard;
        logic [15:0] held[$];
        int unsigned drop_lo;
        int unsigned drop_hi;
        res_t pending[$];
        int errors;

        function new();
            drop_lo = 0;
            drop_hi = 0;
            errors = 0;
        endfunction

        function logic [31:0] isqrt(longint unsigned v);
            longint unsigned r;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                    r = r | (64'd1 << b);
            end
            return r[31:0];
        endfunction

        function void note_request(req_t rq);
            res_t e;
            logic [15:0] s[$];
            longint unsigned sum, sq, var_q, num, den;
            int unsigned used, lo, hi;
            case (rq.op)
                OP_ADD:
                    if (held.size() < DEPTH)
                        held.push_back(rq.rate);
                OP_CLEAR:
                    held.delete();
                OP_COMPUTE:
                begin
                    s = held;
                    s.sort();
                    e = '0;
                    e.sample_count = 7'(s.size());
                    if (s.size() > drop_lo + drop_hi)
                    begin
                        lo = drop_lo;
                        hi = s.size() - drop_hi - 1;
                        used = hi - lo + 1;
                        sum = 0;
                        sq = 0;
                        for (int i = lo; i <= hi; i++)
                        begin
                            sum += s[i];
                            sq += longint'(s[i]) * s[i];
                        end
                        var_q = 0;
                        if (used > 1)
                        begin
                            num = used * sq - sum * sum;
                            den = used * (used - 1);
                            var_q = num / den;
                            if (var_q > 64'hFFFF_FFFF)
                                var_q = 64'hFFFF_FFFF;
                        end
                        e.stats_valid = 1'b1;
                        e.mean_value = 16'(sum / used);
                        e.variance_value = var_q[31:0];
                        e.std_deviation = 16'(isqrt(var_q));
                        e.min_value = s[lo];
                        e.max_value = s[hi];
                    end
                    pending.push_back(e);
                end
                default:;
            endcase
        endfunction

        function void check_result(res_t r);
            res_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.stats_valid !== e.stats_valid)
                begin $error("stats_valid exp %0d got %0d", e.stats_valid, r.stats_valid); errors++; end
            if (r.sample_count !== e.sample_count)
                begin $error("sample_count exp %0d got %0d", e.sample_count, r.sample_count); errors++; end
            if (r.mean_value !== e.mean_value)
                begin $error("mean_value exp %0h got %0h", e.mean_value, r.mean_value); errors++; end
            if (r.variance_value !== e.variance_value)
                begin $error("variance_value exp %0h got %0h", e.variance_value, r.variance_value); errors++; end
            if (r.std_deviation !== e.std_deviation)
                begin $error("std_deviation exp %0h got %0h", e.std_deviation, r.std_deviation); errors++; end
            if (r.min_value !== e.min_value)
                begin $error("min_value exp %0h got %0h", e.min_value, r.min_value); errors++; end
            if (r.max_value !== e.max_value)
                begin $error("max_value exp %0h got %0h", e.max_value, r.max_value); errors++; end
        endfunction
    endclass

    logic clk, rst_n, req_valid, req_ready, res_valid, res_ready, cfg_we, cfg_index;
    logic [5:0] cfg_data;
    req_t req;
    res_t res;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    stats_scoreboard board;

    trimmed_sample_statistics dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_off)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.check_result(res);
    end

    // drive one request; returns at the accepting edge with valid still high
    task automatic send(input logic [1:0] op, input logic [15:0] rate);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req.op <= op;
        req.rate <= rate;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request('{op: op, rate: rate});
    endtask

    // drop valid after the last request of a sequence
    task automatic release_req();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] val);
        release_req();
        // drain, then let an in-flight add or clear settle
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DISCARD_LOW)
            board.drop_lo = val;
        else
            board.drop_hi = val;
    endtask

    task automatic add_burst(input int n, input int mode);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: send(OP_ADD, 16'($urandom));
                1: send(OP_ADD, 16'($urandom_range(16'h0200, 16'h0100)));
                default: send(OP_ADD, $urandom_range(1) ? 16'hFFFF : 16'h0000);
            endcase
        end
    endtask

    task automatic random_phase(input int n);
        int sent;
        int k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                k = $urandom_range(3);
                send(2'(k), 16'($urandom));
                sent++;
            end
            else
            begin
                send(OP_CLEAR, 16'($urandom));
                k = ($urandom_range(7) == 0) ? $urandom_range(80, 60) : $urandom_range(20, 1);
                add_burst(k, $urandom_range(2));
                send(OP_COMPUTE, 16'($urandom));
                sent += k + 2;
            end
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        res_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DISCARD_LOW;
        cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 56;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, single sample, extremes, full store, unknown op
        send(OP_COMPUTE, 16'h0000);
        send(OP_ADD, 16'hFFFF);
        send(OP_COMPUTE, 16'h0000);
        send(OP_ADD, 16'h0000);
        send(2'd3, 16'hFFFF);
        send(OP_COMPUTE, 16'h0000);
        send(OP_CLEAR, 16'h0000);
        add_burst(66, 2);
        send(OP_COMPUTE, 16'h0000);
        send(OP_COMPUTE, 16'h0000);
        write_reg(CFG_DISCARD_LOW, 6'd63);
        write_reg(CFG_DISCARD_HIGH, 6'd63);
        send(OP_COMPUTE, 16'h0000);
        write_reg(CFG_DISCARD_HIGH, 6'd0);
        send(OP_COMPUTE, 16'h0000);
        write_reg(CFG_DISCARD_LOW, 6'd0);
        write_reg(CFG_DISCARD_HIGH, 6'd63);
        send(OP_COMPUTE, 16'h0000);
        write_reg(CFG_DISCARD_HIGH, 6'd0);

        random_phase(450);
        write_reg(CFG_DISCARD_LOW, 6'd2);
        write_reg(CFG_DISCARD_HIGH, 6'd3);
        send_idle_pct = 56;
        recv_idle_pct = 13;
        random_phase(450);

        // long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                send(OP_CLEAR, 16'h0);
                add_burst(5, 0);
                repeat (3) send(OP_COMPUTE, 16'h0);
                release_req();
            end
        join

        write_reg(CFG_DISCARD_LOW, 6'd1);
        write_reg(CFG_DISCARD_HIGH, 6'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(450);
        write_reg(CFG_DISCARD_LOW, 6'd0);
        write_reg(CFG_DISCARD_HIGH, 6'd1);
        random_phase(450);
        release_req();

        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
